FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a whole property, masked while rst is high.
`define VPSHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent same-cycle implication, masked while rst is high.
`define VPSHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vpshp_pkg.sv
`timescale 1ns / 1ps

package vpshp_pkg;

  localparam int WORD_W    = 32;
  localparam int REV_W     = 8;
  localparam int HEIGHT_W  = 16;
  localparam int ROW_W     = 17;
  localparam int CNT_W     = 4;
  localparam int SNUM_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Serial divider: dividend covers (slice + 1) * aligned height.
  localparam int DIV_W     = 20;
  localparam int DIV_CNT_W = 5;
  localparam int REM_W     = 3;

  localparam logic [REV_W-1:0]    REV_F        = 8'h66;
  localparam logic [REV_W-1:0]    REV_G        = 8'h67;
  localparam logic [REV_W-1:0]    REV_RESET    = 8'h61;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;
  localparam logic [ROW_W-1:0]    ROW_ROUND    = 17'd31;
  localparam logic [ROW_W-1:0]    ROW_MASK     = 17'h1FFE0;
  localparam logic [ROW_W-1:0]    WINDOW_PAD   = 17'd63;
  localparam logic [ROW_W-1:0]    ROW_STEP     = 17'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVISION    = 2'd0,
    CFG_VIDEO_FLAGS = 2'd1,
    CFG_HEIGHT      = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PS_OK         = 2'd0,
    PS_SHORT      = 2'd1,
    PS_DECREASING = 2'd2,
    PS_BEYOND     = 2'd3
  } parse_status_t;

  typedef enum logic [1:0] {
    OC_NONE,
    OC_ERROR,
    OC_FRAME
  } outcome_t;

  typedef enum logic [2:0] {
    ST_INPUT,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH,
    ST_OUTPUT
  } ctrl_state_t;

  typedef struct packed {
    logic [REV_W-1:0]    revision;
    logic [WORD_W-1:0]   vid_flags;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic load_out;
    logic next_slice;
  } dp_cmd_t;

  typedef struct packed {
    outcome_t outcome;
    logic     need_div;
    logic     div_last;
    logic     out_last;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] table_count(input logic [1:0] sel);
    logic [CNT_W-1:0] n;
    case (sel)
      2'd0:    n = 4'd2;
      2'd1:    n = 4'd3;
      2'd2:    n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] align32(input logic [ROW_W-1:0] v);
    return (v + ROW_ROUND) & ROW_MASK;
  endfunction

endpackage

FILE: rtl/vpshp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpshp_ctrl
  import vpshp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INPUT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INPUT: begin
        if (in_valid) begin
          case (status.outcome)
            OC_ERROR: state_next = ST_OUTPUT;
            OC_FRAME: state_next = ST_PREP;
            default:  state_next = ST_INPUT;
          endcase
        end
      end
      ST_PREP: begin
        state_next = status.need_div ? ST_DIVIDE : ST_OUTPUT;
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!out_stall) begin
          state_next = status.out_last ? ST_INPUT : ST_PREP;
        end
      end
      default: begin
        state_next = ST_INPUT;
      end
    endcase
  end

  always_comb begin
    in_stall       = (state != ST_INPUT);
    out_valid      = (state == ST_OUTPUT);
    cmd.accept     = (state == ST_INPUT) && in_valid;
    cmd.div_start  = (state == ST_PREP) && status.need_div;
    cmd.div_step   = (state == ST_DIVIDE);
    cmd.load_out   = ((state == ST_PREP) && !status.need_div) || (state == ST_FINISH);
    cmd.next_slice = (state == ST_OUTPUT) && !out_stall && !status.out_last;
  end

  `VPSHP_ASSERT_IMPL(a_sides_exclusive, !in_stall, !out_valid, "input open while result shown")
  `VPSHP_ASSERT(a_divide_ends, (state == ST_DIVIDE && status.div_last) |=> (state == ST_FINISH), "divider end missed")
  `VPSHP_ASSERT(a_show_follows_load, cmd.load_out |=> out_valid, "loaded result not shown")

endmodule

FILE: rtl/vpshp_dp.sv
`timescale 1ns / 1ps

module vpshp_dp
  import vpshp_pkg::*;
#(
  parameter int MAX_SLICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [WORD_W-1:0]   packet_word,
  input  logic                first_word,
  input  logic [WORD_W-1:0]   packet_bytes,
  output logic [SNUM_W-1:0]   slice_number,
  output logic [WORD_W-1:0]   slice_offset,
  output logic [ROW_W-1:0]    slice_end_row,
  output logic [WORD_W-1:0]   frame_flag_bits,
  output logic [CNT_W-1:0]    slice_total,
  output logic [1:0]          parse_status,
  output logic                last_result
);

  localparam int IDX_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int POS_W = $clog2(MAX_SLICES + 1);

  // Parse state
  logic [POS_W-1:0]  word_position;
  logic [CNT_W-1:0]  slice_count_reg;
  logic [WORD_W-1:0] flags_latch;
  logic [WORD_W-1:0] previous_offset;
  logic [WORD_W-1:0] length_latch;
  logic              done_flag;
  logic [WORD_W-1:0] offset_store [MAX_SLICES];

  // Emission state
  logic [SNUM_W-1:0] slice_idx;
  logic [ROW_W-1:0]  win_start;
  logic [ROW_W-1:0]  win_end;

  // Serial divider
  logic [DIV_W-1:0]     div_quo;
  logic [REM_W-1:0]     div_rem;
  logic [CNT_W-1:0]     div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [REM_W:0]       div_trial;
  logic                 div_fit;

  // Result register
  logic [SNUM_W-1:0] out_number;
  logic [WORD_W-1:0] out_offset;
  logic [ROW_W-1:0]  out_row;
  logic [WORD_W-1:0] out_flags;
  logic [CNT_W-1:0]  out_total;
  parse_status_t     out_status;
  logic              out_last;

  // Decode
  logic               new_rev;
  logic [CNT_W-1:0]   first_count;
  logic               short_pkt;
  logic               too_many;
  logic [POS_W-1:0]   pos_inc;
  logic               table_full;
  outcome_t           outcome;
  parse_status_t      err_status;
  logic [CNT_W-1:0]   err_total;

  // Row arithmetic
  logic [ROW_W-1:0]       a_row;
  logic [CNT_W-1:0]       slice_ord;
  logic                   slice_last;
  logic                   need_div;
  logic [ROW_W-1:0]       win_width;
  logic [CNT_W+ROW_W-1:0] prod_full;
  logic [DIV_W-1:0]       div_dividend;
  logic [CNT_W-1:0]       div_divisor;
  logic [ROW_W-1:0]       quo_row;
  logic [ROW_W-1:0]       shrink_start;
  logic [ROW_W-1:0]       end_dec;
  logic [ROW_W-1:0]       row_value;

  always_comb begin
    new_rev = (cfg.revision > REV_G);
    if (cfg.revision == REV_F || cfg.revision == REV_G) begin
      first_count = cfg.vid_flags[0] ? CNT_W'(2) : CNT_W'(1);
    end else if (new_rev) begin
      first_count = table_count(cfg.vid_flags[1:0]);
    end else begin
      first_count = CNT_W'(1);
    end
    short_pkt  = packet_bytes < WORD_W'({first_count, 2'b00});
    too_many   = first_count > CNT_W'(MAX_SLICES);
    pos_inc    = word_position + POS_W'(1);
    table_full = CNT_W'(pos_inc) >= slice_count_reg;
    err_total  = first_word ? first_count : slice_count_reg;
  end

  always_comb begin
    outcome    = OC_NONE;
    err_status = PS_OK;
    if (first_word) begin
      if (short_pkt || too_many) begin
        outcome    = OC_ERROR;
        err_status = PS_SHORT;
      end else if (first_count == CNT_W'(1)) begin
        outcome = OC_FRAME;
      end
    end else if (!done_flag) begin
      if (packet_word < previous_offset) begin
        outcome    = OC_ERROR;
        err_status = PS_DECREASING;
      end else if (packet_word >= length_latch) begin
        outcome    = OC_ERROR;
        err_status = PS_BEYOND;
      end else if (table_full) begin
        outcome = OC_FRAME;
      end
    end
  end

  always_comb begin
    a_row      = align32({1'b0, cfg.height});
    slice_ord  = CNT_W'(slice_idx) + CNT_W'(1);
    slice_last = (slice_ord == slice_count_reg);
    // With more than one slice, old revisions divide every row; new ones all but the last.
    need_div   = (slice_count_reg > CNT_W'(1)) && (!new_rev || !slice_last);
    win_width  = (win_end > win_start) ? (win_end - win_start) : '0;
    prod_full  = slice_ord * a_row;
    if (new_rev) begin
      div_dividend = DIV_W'(win_width);
      div_divisor  = slice_count_reg - CNT_W'(slice_idx);
    end else begin
      div_dividend = DIV_W'(prod_full);
      div_divisor  = slice_count_reg;
    end
    quo_row      = div_quo[ROW_W-1:0];
    shrink_start = win_start + (quo_row & ROW_MASK);
    end_dec      = (win_end >= ROW_STEP) ? (win_end - ROW_STEP) : '0;
    if (!need_div) begin
      row_value = a_row;
    end else if (new_rev) begin
      row_value = shrink_start;
    end else begin
      row_value = align32(quo_row);
    end
    div_trial = {div_rem, div_quo[DIV_W-1]};
    div_fit   = div_trial >= div_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position   <= '0;
      slice_count_reg <= CNT_W'(1);
      flags_latch     <= '0;
      previous_offset <= '0;
      length_latch    <= '0;
      done_flag       <= 1'b1;
    end else if (cmd.accept) begin
      if (first_word) begin
        slice_count_reg <= first_count;
        flags_latch     <= packet_word;
        length_latch    <= packet_bytes;
        previous_offset <= '0;
      end else if (!done_flag && outcome != OC_ERROR) begin
        previous_offset <= packet_word;
      end
      // Go idle on any result; otherwise open or advance the table.
      if (outcome != OC_NONE) begin
        done_flag     <= 1'b1;
        word_position <= '0;
      end else if (first_word) begin
        done_flag     <= 1'b0;
        word_position <= POS_W'(1);
      end else if (!done_flag) begin
        word_position <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !first_word && !done_flag && outcome != OC_ERROR) begin
      offset_store[word_position[IDX_W-1:0]] <= packet_word;
    end
    if (cmd.accept && outcome == OC_FRAME) begin
      slice_idx <= '0;
      win_start <= '0;
      win_end   <= a_row + WINDOW_PAD;
    end
    if (cmd.accept && outcome == OC_ERROR) begin
      out_number <= '0;
      out_offset <= '0;
      out_row    <= '0;
      out_flags  <= '0;
      out_total  <= err_total;
      out_status <= err_status;
      out_last   <= 1'b1;
    end
    if (cmd.div_start) begin
      div_quo <= div_dividend;
      div_rem <= '0;
      div_den <= div_divisor;
      div_cnt <= DIV_CNT_W'(DIV_W - 1);
    end
    if (cmd.div_step) begin
      div_rem <= div_fit ? REM_W'(div_trial - div_den) : REM_W'(div_trial);
      div_quo <= {div_quo[DIV_W-2:0], div_fit};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_number <= slice_idx;
      out_offset <= (slice_idx == '0) ? '0 : offset_store[slice_idx[IDX_W-1:0]];
      out_row    <= row_value;
      out_flags  <= flags_latch;
      out_total  <= slice_count_reg;
      out_status <= PS_OK;
      out_last   <= slice_last;
      if (need_div && new_rev) begin
        win_start <= shrink_start;
        win_end   <= end_dec;
      end
    end
    if (cmd.next_slice) begin
      slice_idx <= slice_idx + SNUM_W'(1);
    end
  end

  always_comb begin
    status.outcome  = outcome;
    status.need_div = need_div;
    status.div_last = (div_cnt == '0);
    status.out_last = out_last;
  end

  assign slice_number    = out_number;
  assign slice_offset    = out_offset;
  assign slice_end_row   = out_row;
  assign frame_flag_bits = out_flags;
  assign slice_total     = out_total;
  assign parse_status    = out_status;
  assign last_result     = out_last;

endmodule

FILE: rtl/video_packet_slice_header_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Slice-table parser for video frame packets. Feed the leading 32-bit words
// of a packet with the packet byte length; first_word marks the frame flags
// word and restarts any parse in progress. The slice count comes from the
// revision letter and video flags, the next count-1 words are slice offsets,
// checked never to fall and to stay inside the packet. When the table is
// complete the block emits one item per slice (offset and 32-aligned end
// row), or a single flagged item on any error, and accepts no input until
// the final item of the packet has been taken. A result's end row needs no
// division for single-slice frames and the last slice of later revisions;
// every other end row passes through the shared serial divider, which
// retires one quotient bit per cycle over a 20-bit dividend. An error item
// is shown in the cycle after its word is taken. Configuration is written
// through cfg_write/cfg_index/cfg_data; the user must write it only while
// idle, and the block itself does not enforce this. Indexes beyond the
// register list are ignored. No clearing pass is needed after reset.

module video_packet_slice_header_parser
  import vpshp_pkg::*;
#(
  parameter int MAX_SLICES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     packet_word,
  input  logic                  first_word,
  input  logic [WORD_W-1:0]     packet_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SNUM_W-1:0]     slice_number,
  output logic [WORD_W-1:0]     slice_offset,
  output logic [ROW_W-1:0]      slice_end_row,
  output logic [WORD_W-1:0]     frame_flag_bits,
  output logic [CNT_W-1:0]      slice_total,
  output logic [1:0]            parse_status,
  output logic                  last_result
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers: hold until written, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.revision  <= REV_RESET;
      cfg.vid_flags <= '0;
      cfg.height    <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REVISION:    cfg.revision  <= cfg_data[REV_W-1:0];
        CFG_VIDEO_FLAGS: cfg.vid_flags <= cfg_data;
        CFG_HEIGHT:      cfg.height    <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept words, step the divider, present each item.
  vpshp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Parse registers, offset table, divider and result register.
  vpshp_dp #(
    .MAX_SLICES (MAX_SLICES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .packet_word     (packet_word),
    .first_word      (first_word),
    .packet_bytes    (packet_bytes),
    .slice_number    (slice_number),
    .slice_offset    (slice_offset),
    .slice_end_row   (slice_end_row),
    .frame_flag_bits (frame_flag_bits),
    .slice_total     (slice_total),
    .parse_status    (parse_status),
    .last_result     (last_result)
  );

  `VPSHP_ASSERT_IMPL(a_error_is_last, out_valid && (parse_status != PS_OK), last_result, "error item not marked last")
  `VPSHP_ASSERT_IMPL(a_slice_in_range, out_valid && (parse_status == PS_OK), CNT_W'(slice_number) < slice_total, "slice number beyond total")
  `VPSHP_ASSERT(a_last_reopens_input, (out_valid && !out_stall && last_result) |=> !in_stall, "input not reopened after last item")

endmodule

FILE: tb/slice_table_checker.sv
`timescale 1ns / 1ps

module slice_table_checker
  import vpshp_pkg::*;
#(
  parameter int MAX_SLICES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_W-1:0]    packet_word,
  input  logic                 first_word,
  input  logic [WORD_W-1:0]    packet_bytes,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SNUM_W-1:0]    slice_number,
  input  logic [WORD_W-1:0]    slice_offset,
  input  logic [ROW_W-1:0]     slice_end_row,
  input  logic [WORD_W-1:0]    frame_flag_bits,
  input  logic [CNT_W-1:0]     slice_total,
  input  logic [1:0]           parse_status,
  input  logic                 last_result,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct {
    logic [SNUM_W-1:0] number;
    logic [WORD_W-1:0] offset;
    logic [ROW_W-1:0]  end_row;
    logic [WORD_W-1:0] flags;
    logic [CNT_W-1:0]  total;
    parse_status_t     status;
    logic              last;
  } slice_result_t;

  slice_result_t pending_slices[$];

  logic [REV_W-1:0]    rev_letter;
  logic [WORD_W-1:0]   vid_flags;
  logic [HEIGHT_W-1:0] height;

  logic [3:0]          word_pos;
  logic [CNT_W-1:0]    n_slices;
  logic [WORD_W-1:0]   flags_seen;
  logic [WORD_W-1:0]   offsets [8];
  logic [WORD_W-1:0]   prev_off;
  logic [WORD_W-1:0]   length_seen;
  logic                idle;

  int fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic [CNT_W-1:0] slices_for_revision();
    logic [CNT_W-1:0] n;
    n = 1;
    if (rev_letter == REV_F || rev_letter == REV_G) begin
      n = vid_flags[0] ? 4'd2 : 4'd1;
    end else if (rev_letter > REV_G) begin
      case (vid_flags[1:0])
        2'd0:    n = 2;
        2'd1:    n = 3;
        2'd2:    n = 4;
        default: n = 8;
      endcase
    end
    return n;
  endfunction

  task automatic push_parse_error(input parse_status_t st);
    slice_result_t r;
    r.number  = '0;
    r.offset  = '0;
    r.end_row = '0;
    r.flags   = '0;
    r.total   = n_slices;
    r.status  = st;
    r.last    = 1'b1;
    pending_slices.push_back(r);
    idle     = 1'b1;
    word_pos = '0;
  endtask

  // One slice takes the aligned height; else later revisions split a shrinking window, older ones divide in proportion.
  task automatic push_slice_rows();
    logic [31:0]   aligned;
    logic [31:0]   start;
    logic [31:0]   stop;
    logic [31:0]   width;
    logic [31:0]   rows [8];
    int            n;
    slice_result_t r;
    n       = int'(n_slices);
    aligned = (32'(height) + 32'd31) & ~32'd31;
    if (n <= 1) begin
      rows[0] = aligned;
    end else if (rev_letter > REV_G) begin
      start = 0;
      stop  = aligned + 32'd63;
      for (int i = 0; i < n - 1; i++) begin
        width   = (stop > start) ? stop - start : 32'd0;
        start   = start + ((width / 32'(n - i)) & ~32'd31);
        stop    = (stop >= 32'd32) ? stop - 32'd32 : 32'd0;
        rows[i] = start;
      end
      rows[n-1] = aligned;
    end else begin
      for (int i = 0; i < n; i++)
        rows[i] = (((32'(i + 1) * aligned) / 32'(n)) + 32'd31) & ~32'd31;
    end
    for (int i = 0; i < n; i++) begin
      r.number  = i[SNUM_W-1:0];
      r.offset  = (i == 0) ? '0 : offsets[i];
      r.end_row = rows[i][ROW_W-1:0];
      r.flags   = flags_seen;
      r.total   = n_slices;
      r.status  = PS_OK;
      r.last    = (i == n - 1);
      pending_slices.push_back(r);
    end
    idle     = 1'b1;
    word_pos = '0;
  endtask

  task automatic take_packet_word(input logic [WORD_W-1:0] word, input logic first,
                                  input logic [WORD_W-1:0] bytes);
    if (first) begin
      n_slices    = slices_for_revision();
      flags_seen  = word;
      length_seen = bytes;
      prev_off    = '0;
      offsets[0]  = '0;
      idle        = 1'b0;
      if (bytes < 4 || n_slices > MAX_SLICES || {1'b0, bytes} < 33'(n_slices) * 4)
        push_parse_error(PS_SHORT);
      else if (n_slices == 1)
        push_slice_rows();
      else
        word_pos = 1;
    end else if (!idle) begin
      if (word < prev_off) begin
        push_parse_error(PS_DECREASING);
      end else if (word >= length_seen) begin
        push_parse_error(PS_BEYOND);
      end else begin
        offsets[word_pos[2:0]] = word;
        prev_off = word;
        word_pos = word_pos + 4'd1;
        if (word_pos >= n_slices)
          push_slice_rows();
      end
    end
  endtask

  always @(posedge clk) begin
    slice_result_t exp_r;
    if (rst) begin
      rev_letter  = REV_RESET;
      vid_flags   = '0;
      height      = HEIGHT_RESET;
      word_pos    = '0;
      n_slices    = 1;
      flags_seen  = '0;
      prev_off    = '0;
      length_seen = '0;
      idle        = 1'b1;
      for (int i = 0; i < 8; i++)
        offsets[i] = '0;
      pending_slices.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_slices.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected slice item: num=%0d off=%h row=%0d status=%0d last=%b",
                     slice_number, slice_offset, slice_end_row, parse_status, last_result);
        end else begin
          exp_r = pending_slices.pop_front();
          if (slice_number !== exp_r.number || slice_offset !== exp_r.offset ||
              slice_end_row !== exp_r.end_row || frame_flag_bits !== exp_r.flags ||
              slice_total !== exp_r.total || parse_status !== exp_r.status ||
              last_result !== exp_r.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("slice item differs: expected num=%0d off=%h row=%0d flags=%h total=%0d status=%0d last=%b",
                       exp_r.number, exp_r.offset, exp_r.end_row, exp_r.flags,
                       exp_r.total, exp_r.status, exp_r.last);
              $display("                    actual   num=%0d off=%h row=%0d flags=%h total=%0d status=%0d last=%b",
                       slice_number, slice_offset, slice_end_row, frame_flag_bits,
                       slice_total, parse_status, last_result);
            end
          end
        end
      end
      if (cfg_write === 1'b1) begin
        case (cfg_index)
          CFG_REVISION:    rev_letter = cfg_data[REV_W-1:0];
          CFG_VIDEO_FLAGS: vid_flags  = cfg_data;
          CFG_HEIGHT:      height     = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        take_packet_word(packet_word, first_word, packet_bytes);
    end
    outstanding <= pending_slices.size();
  end

endmodule

FILE: tb/tb_video_packet_slice_header_parser.sv
`timescale 1ns / 1ps

module tb_video_packet_slice_header_parser;
  import vpshp_pkg::*;

  // Run length and pacing.
  localparam int CYCLE_LIMIT     = 300000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 21;

  typedef enum {
    PK_GOOD,
    PK_SHORT,
    PK_DECREASING,
    PK_BEYOND,
    PK_TRUNCATED
  } packet_shape_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_REVISION;
  logic [WORD_W-1:0]    cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    packet_word  = '0;
  logic                 first_word   = 1'b0;
  logic [WORD_W-1:0]    packet_bytes = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [SNUM_W-1:0]    slice_number;
  logic [WORD_W-1:0]    slice_offset;
  logic [ROW_W-1:0]     slice_end_row;
  logic [WORD_W-1:0]    frame_flag_bits;
  logic [CNT_W-1:0]     slice_total;
  logic [1:0]           parse_status;
  logic                 last_result;

  int fails;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  int tx_idle_pct = 37;
  int rx_idle_pct = 58;

  // Our own copy of the configuration, used only to shape well-formed packets.
  logic [REV_W-1:0]  cur_rev   = REV_RESET;
  logic [WORD_W-1:0] cur_flags = '0;

  video_packet_slice_header_parser uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .packet_word     (packet_word),
    .first_word      (first_word),
    .packet_bytes    (packet_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slice_number    (slice_number),
    .slice_offset    (slice_offset),
    .slice_end_row   (slice_end_row),
    .frame_flag_bits (frame_flag_bits),
    .slice_total     (slice_total),
    .parse_status    (parse_status),
    .last_result     (last_result)
  );

  slice_table_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .packet_word     (packet_word),
    .first_word      (first_word),
    .packet_bytes    (packet_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slice_number    (slice_number),
    .slice_offset    (slice_offset),
    .slice_end_row   (slice_end_row),
    .frame_flag_bits (frame_flag_bits),
    .slice_total     (slice_total),
    .parse_status    (parse_status),
    .last_result     (last_result),
    .mismatches      (fails),
    .outstanding     (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: stall at random at the current rate, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Slice count as the block derives it; needed to build complete offset tables.
  function automatic int slice_count_for(input logic [REV_W-1:0] rev,
                                         input logic [WORD_W-1:0] flags);
    int n;
    n = 1;
    if (rev == REV_F || rev == REV_G)
      n = flags[0] ? 2 : 1;
    else if (rev > REV_G)
      n = (flags[1:0] == 2'd3) ? 8 : 2 + flags[1:0];
    return n;
  endfunction

  // Packet length long enough for n offsets: the minimum, small, huge or the maximum.
  function automatic logic [WORD_W-1:0] pick_length(input int n);
    logic [WORD_W-1:0] len;
    case ($urandom_range(3))
      0:       len = 4 * n;
      1:       len = $urandom_range(4 * n + 300, 4 * n);
      2:       len = $urandom_range(32'hFFFF_FFFF, 4 * n);
      default: len = 32'hFFFF_FFFF;
    endcase
    return len;
  endfunction

  // Offer one item, idling first at the sender's rate, and hold it until taken.
  task automatic send_word(input logic [WORD_W-1:0] word, input logic first,
                           input logic [WORD_W-1:0] bytes, input bit counted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    packet_word  <= word;
    first_word   <= first;
    packet_bytes <= bytes;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    if (counted)
      items_sent++;
  endtask

  // Write all three registers once the block has drained and settled.
  task automatic write_config(input logic [REV_W-1:0] rev, input logic [WORD_W-1:0] flags,
                              input logic [HEIGHT_W-1:0] rows);
    logic [WORD_W-1:0] junk;
    junk = $urandom;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // Upper data bits beyond each register's width are noise; toggle them too.
    cfg_write <= 1'b1;
    cfg_index <= CFG_REVISION;
    cfg_data  <= {junk[31:REV_W], rev};
    @(posedge clk);
    cfg_index <= CFG_VIDEO_FLAGS;
    cfg_data  <= flags;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= {junk[15:0], rows};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_rev   = rev;
    cur_flags = flags;
  endtask

  // One packet: flags word, then offsets that never fall, broken as the shape asks.
  task automatic send_packet(input packet_shape_t kind);
    packet_shape_t     shape;
    int                n;
    int                stop_at;
    logic [WORD_W-1:0] bytes;
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] room;
    shape = kind;
    n     = slice_count_for(cur_rev, cur_flags);
    // A single-slice frame has no offsets to break; a falling offset needs two before it.
    if (n == 1 && shape != PK_SHORT)
      shape = PK_GOOD;
    if (shape == PK_DECREASING && n < 3)
      shape = PK_BEYOND;
    bytes = (shape == PK_SHORT) ? 32'($urandom_range(4 * n - 1, 0)) : pick_length(n);
    case (shape)
      PK_DECREASING: stop_at = $urandom_range(n - 1, 2);
      PK_BEYOND:     stop_at = $urandom_range(n - 1, 1);
      PK_TRUNCATED:  stop_at = $urandom_range(n - 2, 0);
      default:       stop_at = n;
    endcase
    send_word($urandom, 1'b1, bytes, 1'b1);
    if (shape == PK_SHORT)
      return;
    prev = '0;
    for (int i = 1; i < n; i++) begin
      if (shape == PK_TRUNCATED && i > stop_at)
        return;
      if (shape == PK_DECREASING && i == stop_at) begin
        send_word($urandom_range(prev - 1, 0), 1'b0, bytes, 1'b1);
        return;
      end
      if (shape == PK_BEYOND && i == stop_at) begin
        send_word($urandom_range(32'hFFFF_FFFF, bytes), 1'b0, bytes, 1'b1);
        return;
      end
      // Keep room for the offsets still to come; repeat the previous one now and then.
      room = (bytes - 32'd1 - prev) / 32'(n - i);
      off  = prev + $urandom_range(room, (shape == PK_DECREASING && i == 1) ? 1 : 0);
      if ($urandom_range(7) == 0 && !(shape == PK_DECREASING && i == 1))
        off = prev;
      send_word(off, 1'b0, bytes, 1'b1);
      prev = off;
    end
  endtask

  initial begin
    int          roll;
    int          phase_start;
    logic [7:0]  rev;
    logic [15:0] rows;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset revision, single slice, shortest lengths and an idle word.
    write_config(REV_RESET, 32'h0, 16'd1);
    send_word(32'hFFFF_FFFF, 1'b1, 32'd4, 1'b1);
    send_word(32'h0, 1'b1, 32'd3, 1'b1);
    send_word(32'hDEAD_BEEF, 1'b0, 32'd50, 1'b0);
    send_word(32'h1234_5678, 1'b1, 32'd0, 1'b1);

    // Eight slices, zero height, packet exactly as long as the table.
    write_config(8'h68, 32'h3, 16'd0);
    send_word($urandom, 1'b1, 32'd32, 1'b1);
    send_word(32'd0, 1'b0, 32'd32, 1'b1);
    send_word(32'd0, 1'b0, 32'd32, 1'b1);
    send_word(32'd4, 1'b0, 32'd32, 1'b1);
    send_word(32'd9, 1'b0, 32'd32, 1'b1);
    send_word(32'd17, 1'b0, 32'd32, 1'b1);
    send_word(32'd25, 1'b0, 32'd32, 1'b1);
    send_word(32'd31, 1'b0, 32'd32, 1'b1);

    // Revision f with two slices, tallest frame: widest offset, beyond, short.
    write_config(REV_F, 32'h1, 16'hFFFF);
    send_word(32'hA5A5_A5A5, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h5A5A_5A5A, 1'b1, 32'd100, 1'b1);
    send_word(32'd100, 1'b0, 32'd100, 1'b1);
    send_word(32'h0F0F_0F0F, 1'b1, 32'd7, 1'b1);

    // Top revision code, four slices: falling offset, restart mid-packet, equal offsets.
    write_config(8'hFF, 32'h2, 16'hFFFF);
    send_word($urandom, 1'b1, 32'd1000, 1'b1);
    send_word(32'd10, 1'b0, 32'd1000, 1'b1);
    send_word(32'd9, 1'b0, 32'd1000, 1'b1);
    send_word($urandom, 1'b1, 32'd16, 1'b1);
    send_word(32'd5, 1'b0, 32'd16, 1'b1);
    send_word($urandom, 1'b1, 32'd16, 1'b1);
    send_word(32'd15, 1'b0, 32'd16, 1'b1);
    send_word(32'd15, 1'b0, 32'd16, 1'b1);
    send_word(32'd15, 1'b0, 32'd16, 1'b1);

    // Random phases: cycle through revision classes, swap the idling sides
    // after a third of the run and drop idling in the last third.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 3)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (p % 8)
        0:       rev = 8'h00;   // earliest
        1:       rev = 8'h65;   // just below f
        2:       rev = REV_F;
        3:       rev = REV_G;
        4:       rev = 8'h68;   // first later revision
        5:       rev = 8'h80;   // unsigned compare
        6:       rev = 8'hFF;
        default: rev = 8'($urandom);
      endcase
      case ($urandom_range(3))
        0:       rows = 16'd1;
        1:       rows = 16'hFFFF;
        default: rows = 16'($urandom_range(16'hFFFF, 1));
      endcase
      write_config(rev, $urandom, rows);

      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 68) begin
          send_packet(PK_GOOD);
        end else if (roll < 76) begin
          send_packet(PK_SHORT);
        end else if (roll < 84) begin
          send_packet(PK_DECREASING);
        end else if (roll < 91) begin
          send_packet(PK_BEYOND);
        end else if (roll < 96) begin
          // Abandon a table part way and start over with a complete packet.
          send_packet(PK_TRUNCATED);
          send_packet(PK_GOOD);
        end else begin
          // Stray word while idle: the block drops it.
          send_word($urandom, 1'b0, $urandom, 1'b0);
        end
      end
    end

    // Drain: wait for every expected item, then let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
